>>> hw/rtl/rpfd_pkg.sv
// rpfd_pkg: item types, phase encoding and timing thresholds for the
// remote pulse frame decoder. No dependencies.
package rpfd_pkg;

   localparam int CODE_W = 22;
   localparam int DUR_W  = 16;
   localparam int CNT_W  = 8;

   localparam logic OP_EDGE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [2:0] {
      PH_GAP0  = 3'd0,
      PH_GAP1  = 3'd1,
      PH_SYNC  = 3'd2,
      PH_SHORT = 3'd3,
      PH_DATA  = 3'd4,
      PH_READY = 3'd5
   } phase_type;

   typedef struct packed {
      logic             opcode;
      logic [DUR_W-1:0] duration_us;
   } req_type;

   typedef struct packed {
      logic              frame_ready;
      logic [CODE_W-1:0] code_first;
      logic [CODE_W-1:0] code_second;
      logic [CODE_W-1:0] code_third;
   } rsp_type;

   // long gap: strictly between 23 ms and 27 ms
   localparam logic [DUR_W:0] LONG_GAP_LO   = 17'd23000;
   localparam logic [DUR_W:0] LONG_GAP_HI   = 17'd27000;
   // sync pair sum accepted in 500..1100 us
   localparam logic [DUR_W:0] SYNC_PAIR_MIN = 17'd500;
   localparam logic [DUR_W:0] SYNC_PAIR_MAX = 17'd1100;
   // last sync edge accepted in 100..700 us
   localparam logic [DUR_W:0] SYNC_TAIL_MIN = 17'd100;
   localparam logic [DUR_W:0] SYNC_TAIL_MAX = 17'd700;
   localparam logic [CNT_W-1:0] SYNC_EDGES  = 8'd23;
   // short gap accepted in 4700..5700 us
   localparam logic [DUR_W:0] SHORT_GAP_MIN = 17'd4700;
   localparam logic [DUR_W:0] SHORT_GAP_MAX = 17'd5700;
   // data pair sum accepted in 200..2200 us
   localparam logic [DUR_W:0] DATA_PAIR_MIN = 17'd200;
   localparam logic [DUR_W:0] DATA_PAIR_MAX = 17'd2200;
   localparam logic [DUR_W-1:0] DATA_LONG_US = 16'd1200;

endpackage

>>> hw/rtl/rpfd_in_stage.sv
// rpfd_in_stage: input register for edge items with valid/stall handshake.
// Depends on rpfd_pkg for the item type.
module rpfd_in_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rpfd_pkg::req_type req_payload,
   input  logic            advance,
   output logic            item_valid,
   output rpfd_pkg::req_type item
);
   import rpfd_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/rpfd_core.sv
// rpfd_core: decoder state (phase, edge count, previous duration, code words)
// and the single-pass next-state logic. Depends on rpfd_pkg.
module rpfd_core #(
   parameter int BITS_PER_WORD = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              step,
   input  rpfd_pkg::req_type item,
   output rpfd_pkg::rsp_type result
);
   import rpfd_pkg::*;

   localparam int BW    = BITS_PER_WORD;
   localparam int BCNT_W = (BW > 1) ? $clog2(BW) : 1;
   localparam logic [BCNT_W-1:0] LAST_BIT = BCNT_W'(BW - 1);
   localparam logic [CNT_W-1:0] EDGES_PER_FRAME = CNT_W'(6 * BW);

   logic              wait_two_gaps_ff;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DUR_W-1:0]  prev_ff, prev_in;
   logic [BCNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [1:0]        word_sel_ff, word_sel_in;
   logic [BW-1:0]     words_ff [3];
   logic [BW-1:0]     words_in [3];

   phase_type         start_phase;
   logic [DUR_W-1:0]  d;
   logic [DUR_W-1:0]  d_use;
   logic [DUR_W-1:0]  prev_dist;
   logic [CNT_W-1:0]  cnt_inc;
   logic [DUR_W:0]    d_ext;
   logic [DUR_W:0]    pair_sum;
   logic              long_gap;
   logic              data_even;
   logic              bit_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_two_gaps_ff <= 1'b0;
      end else if (csr_wr_en) begin
         wait_two_gaps_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_GAP1;
         cnt_ff      <= '0;
         prev_ff     <= '0;
         bit_cnt_ff  <= '0;
         word_sel_ff <= '0;
         words_ff[0] <= '0;
         words_ff[1] <= '0;
         words_ff[2] <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         prev_ff     <= prev_in;
         bit_cnt_ff  <= bit_cnt_in;
         word_sel_ff <= word_sel_in;
         words_ff    <= words_in;
      end
   end

   assign start_phase = wait_two_gaps_ff ? PH_GAP0 : PH_GAP1;
   assign d           = item.duration_us;
   assign cnt_inc     = cnt_ff + 1'b1;
   assign data_even   = (phase_ff == PH_DATA) & ~cnt_inc[0];
   assign prev_dist   = (prev_ff >= DATA_LONG_US) ? (prev_ff - DATA_LONG_US)
                                                  : (DATA_LONG_US - prev_ff);
   // a long low (over 1200 us) inside a data pair is replaced by the previous duration's distance from 1200 us
   assign d_use       = (data_even && d > DATA_LONG_US) ? prev_dist : d;
   assign d_ext       = {1'b0, d_use};
   assign pair_sum    = {1'b0, prev_ff} + d_ext;
   assign long_gap    = (d_ext > LONG_GAP_LO) & (d_ext < LONG_GAP_HI);
   assign bit_val     = prev_ff > d_use;

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      prev_in     = prev_ff;
      bit_cnt_in  = bit_cnt_ff;
      word_sel_in = word_sel_ff;
      words_in    = words_ff;
      if (item.opcode == OP_RESTART) begin
         phase_in = start_phase;
         cnt_in   = '0;
      end else begin
         prev_in = d_use;
         case (phase_ff)
            PH_GAP0: begin
               if (long_gap) begin
                  phase_in = PH_GAP1;
               end
            end
            PH_GAP1: begin
               if (long_gap) begin
                  phase_in = PH_SYNC;
                  cnt_in   = '0;
               end
            end
            PH_SYNC: begin
               cnt_in = cnt_inc;
               if (!cnt_inc[0] && (pair_sum < SYNC_PAIR_MIN || pair_sum > SYNC_PAIR_MAX)) begin
                  phase_in = start_phase;
                  cnt_in   = '0;
               end
               if (cnt_in >= SYNC_EDGES) begin
                  phase_in = (d_ext < SYNC_TAIL_MIN || d_ext > SYNC_TAIL_MAX) ? start_phase
                                                                             : PH_SHORT;
               end
            end
            PH_SHORT: begin
               if (d_ext < SHORT_GAP_MIN || d_ext > SHORT_GAP_MAX) begin
                  phase_in = start_phase;
               end else begin
                  phase_in    = PH_DATA;
                  cnt_in      = '0;
                  bit_cnt_in  = '0;
                  word_sel_in = '0;
               end
            end
            PH_DATA: begin
               cnt_in = cnt_inc;
               if (data_even) begin
                  if (pair_sum < DATA_PAIR_MIN || pair_sum > DATA_PAIR_MAX) begin
                     phase_in = start_phase;
                  end else begin
                     case (word_sel_ff)
                        2'd0: words_in[0] = (words_ff[0] << 1) | BW'(bit_val);
                        2'd1: words_in[1] = (words_ff[1] << 1) | BW'(bit_val);
                        2'd2: words_in[2] = (words_ff[2] << 1) | BW'(bit_val);
                        default: ;
                     endcase
                     if (bit_cnt_ff == LAST_BIT) begin
                        bit_cnt_in  = '0;
                        word_sel_in = word_sel_ff + 1'b1;
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 1'b1;
                     end
                  end
               end
               // the last edge closes the frame even after a bad pair
               if (cnt_inc >= EDGES_PER_FRAME) begin
                  phase_in = PH_READY;
               end
            end
            default: ;
         endcase
      end
   end

   logic [CODE_W-1:0] code_w [3];

   for (genvar i = 0; i < 3; i++) begin : g_code
      if (BW >= CODE_W) begin : g_trunc
         assign code_w[i] = words_in[i][CODE_W-1:0];
      end else begin : g_ext
         assign code_w[i] = {{(CODE_W - BW){1'b0}}, words_in[i]};
      end
   end

   always_comb begin
      result.frame_ready = (phase_in == PH_READY);
      result.code_first  = result.frame_ready ? code_w[0] : '0;
      result.code_second = result.frame_ready ? code_w[1] : '0;
      result.code_third  = result.frame_ready ? code_w[2] : '0;
   end

endmodule

>>> hw/rtl/remote_pulse_frame_decoder.sv
// remote_pulse_frame_decoder: top level with input stage, decoder core and
// result register. Depends on rpfd_pkg, rpfd_in_stage and rpfd_core.
//
// Decodes an on-off keyed remote frame from edge items (time since previous
// edge, or a restart). Every accepted item yields exactly one result item
// carrying the frame_ready flag and the three code words (zero unless ready).
// An item is taken into the input register, goes through the decoder state
// update when it advances and lands in the result register, so a result is
// presented on the cycle after its item leaves the input register and can be
// taken at the following edge; one item per cycle is sustained while rsp_stall
// is low. The result register lets the next item be taken while a result still
// waits under rsp_stall. csr_wr_data sets wait_two_gaps, which takes effect at
// the next return to the long gap search (a restart or a failed check).
module remote_pulse_frame_decoder #(
   parameter int BITS_PER_WORD = 22
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rpfd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpfd_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import rpfd_pkg::*;

   logic    item_valid;
   req_type item;
   logic    advance;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   assign advance      = item_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   rpfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   rpfd_core #(
      .BITS_PER_WORD (BITS_PER_WORD)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   // a not-ready result never carries code bits
   a_codes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.frame_ready) |->
         (rsp_payload.code_first == '0 && rsp_payload.code_second == '0 &&
          rsp_payload.code_third == '0))
      else $error("code words nonzero while frame not ready");

   // a restart always produces a not-ready result
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && item.opcode == OP_RESTART) |=> (rsp_valid && !rsp_payload.frame_ready))
      else $error("restart did not clear frame_ready");

   // input side only stalls when a held item cannot move on
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item_valid && rsp_valid && rsp_stall))
      else $error("input stalled without a blocked item");
`endif

endmodule
